// ===== hw/rtl/txs_pkg.sv =====
// Shared types, widths and constants of the texture sampler.
`default_nettype none
package txs_pkg;
    localparam int UV_FRAC_BITS = 16;
    localparam int UV_W         = UV_FRAC_BITS + 1;
    localparam int MAX_WIDTH    = 256;
    localparam int MAX_HEIGHT   = 256;
    localparam int STORE_DEPTH  = MAX_WIDTH * MAX_HEIGHT * 4;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);
    localparam int DIM_W        = 9;
    localparam int NC_W         = 3;
    localparam int COORD_W      = $clog2(MAX_WIDTH > MAX_HEIGHT ? MAX_WIDTH : MAX_HEIGHT);
    localparam int TU_W         = UV_W + DIM_W + 1;
    localparam int IX_W         = TU_W - UV_FRAC_BITS;
    localparam int RO_W         = COORD_W + DIM_W;
    localparam int WGT_W        = 2 * UV_FRAC_BITS + 1;
    localparam int ACC_W        = 2 * UV_FRAC_BITS + 9;
    localparam int ROUND_SH     = 2 * UV_FRAC_BITS - 8;
    localparam int COMP_W       = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_W        = 9;
    localparam int QUEUE_DEPTH  = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COMPONENTS = 2'd2;

    localparam logic [0:0] FUNC_WRITE  = 1'b0;
    localparam logic [0:0] FUNC_SAMPLE = 1'b1;

    typedef struct packed {
        logic              smp;
        logic              bil;
        logic [NC_W-1:0]   nc;
        logic [ADDR_W-1:0] b00;
        logic [ADDR_W-1:0] b10;
        logic [ADDR_W-1:0] b01;
        logic [ADDR_W-1:0] b11;
        logic [WGT_W-1:0]  w00;
        logic [WGT_W-1:0]  w10;
        logic [WGT_W-1:0]  w01;
        logic [WGT_W-1:0]  w11;
        logic [7:0]        wval;
    } t_txs_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_DONE
    } t_txs_state;
endpackage
`default_nettype wire

// ===== hw/rtl/txs_front.sv =====
// Front pipeline: scales coordinates, clamps neighbors, forms store addresses and weights.
`default_nettype none
module txs_front
    import txs_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_stall,
    input  wire logic                   i_func,
    input  wire logic [ADDR_W-1:0]      i_byte_addr,
    input  wire logic [7:0]             i_byte_value,
    input  wire logic [UV_W-1:0]        i_u_coord,
    input  wire logic [UV_W-1:0]        i_v_coord,
    input  wire logic                   i_bilinear,
    input  wire logic [CFG_W-1:0]       i_tex_width,
    input  wire logic [CFG_W-1:0]       i_tex_height,
    input  wire logic [NC_W-1:0]        i_components,
    input  wire logic                   i_q_full,
    output logic                        o_q_push,
    output t_txs_item                   o_q_item
);
    localparam logic [TU_W-1:0]  HALF = TU_W'(1) << (UV_FRAC_BITS - 1);
    localparam logic [UV_W-1:0]  ONE  = UV_W'(1) << UV_FRAC_BITS;

    function automatic logic [COORD_W-1:0] clamp_c(input logic signed [IX_W:0] c,
                                                   input logic [DIM_W-1:0] n);
        logic signed [IX_W:0] lim;
        lim = $signed({{(IX_W+1-DIM_W){1'b0}}, n}) - $signed((IX_W+1)'(1));
        if (c < 0) begin
            return '0;
        end else if (c > lim) begin
            return lim[COORD_W-1:0];
        end else begin
            return c[COORD_W-1:0];
        end
    endfunction

    logic en;
    logic [DIM_W-1:0] w_eff, h_eff;
    logic [NC_W-1:0]  nc_eff;

    // stage 1
    logic r1_v, r1_smp, r1_bil;
    logic [TU_W-1:0] r1_tu, r1_tv;
    logic [DIM_W-1:0] r1_w, r1_h;
    logic [NC_W-1:0] r1_nc;
    logic [ADDR_W-1:0] r1_addr;
    logic [7:0] r1_val;
    // stage 2
    logic r2_v, r2_smp, r2_bil;
    logic [COORD_W-1:0] r2_cx0, r2_cx1, r2_cy0, r2_cy1;
    logic [UV_FRAC_BITS-1:0] r2_fu, r2_fv;
    logic [DIM_W-1:0] r2_w;
    logic [NC_W-1:0] r2_nc;
    logic [ADDR_W-1:0] r2_addr;
    logic [7:0] r2_val;
    // stage 3
    logic r3_v, r3_smp, r3_bil;
    logic [COORD_W-1:0] r3_cx0, r3_cx1;
    logic [RO_W-1:0] r3_ro0, r3_ro1;
    logic [WGT_W-1:0] r3_w00, r3_w10, r3_w01, r3_w11;
    logic [NC_W-1:0] r3_nc;
    logic [ADDR_W-1:0] r3_addr;
    logic [7:0] r3_val;
    // stage 4
    logic r4_v;
    t_txs_item r4_item;

    logic [IX_W-1:0] ix, iy;
    logic signed [IX_W:0] x0, x1, y0, y1;
    logic [RO_W-1:0] t00, t10, t01, t11;
    logic [UV_W-1:0] a_u, a_v;
    t_txs_item n4_item;

    assign en       = !r4_v || !i_q_full;
    assign o_stall  = !en;
    assign o_q_push = r4_v && !i_q_full;
    assign o_q_item = r4_item;

    always_comb begin
        if (i_tex_width == '0) begin
            w_eff = DIM_W'(1);
        end else if (i_tex_width > DIM_W'(MAX_WIDTH)) begin
            w_eff = DIM_W'(MAX_WIDTH);
        end else begin
            w_eff = i_tex_width;
        end
        if (i_tex_height == '0) begin
            h_eff = DIM_W'(1);
        end else if (i_tex_height > DIM_W'(MAX_HEIGHT)) begin
            h_eff = DIM_W'(MAX_HEIGHT);
        end else begin
            h_eff = i_tex_height;
        end
        if (i_components == '0) begin
            nc_eff = NC_W'(1);
        end else if (i_components > NC_W'(4)) begin
            nc_eff = NC_W'(4);
        end else begin
            nc_eff = i_components;
        end
    end

    // stage 2 logic: integer part, half-texel shift, clamp
    always_comb begin
        ix = r1_tu[TU_W-1:UV_FRAC_BITS];
        iy = r1_tv[TU_W-1:UV_FRAC_BITS];
        x0 = $signed({1'b0, ix}) - $signed({{IX_W{1'b0}}, r1_bil});
        y0 = $signed({1'b0, iy}) - $signed({{IX_W{1'b0}}, r1_bil});
        x1 = x0 + $signed((IX_W+1)'(1));
        y1 = y0 + $signed((IX_W+1)'(1));
    end

    // stage 3 logic: weight complements
    assign a_u = ONE - UV_W'(r2_fu);
    assign a_v = ONE - UV_W'(r2_fv);

    // stage 4 logic: texel index to byte address
    always_comb begin
        t00 = r3_ro0 + RO_W'(r3_cx0);
        t10 = r3_ro0 + RO_W'(r3_cx1);
        t01 = r3_ro1 + RO_W'(r3_cx0);
        t11 = r3_ro1 + RO_W'(r3_cx1);
        n4_item      = '0;
        n4_item.smp  = r3_smp;
        n4_item.bil  = r3_bil;
        n4_item.nc   = r3_nc;
        n4_item.b00  = r3_smp ? ADDR_W'(ADDR_W'(t00) * ADDR_W'(r3_nc)) : r3_addr;
        n4_item.b10  = ADDR_W'(ADDR_W'(t10) * ADDR_W'(r3_nc));
        n4_item.b01  = ADDR_W'(ADDR_W'(t01) * ADDR_W'(r3_nc));
        n4_item.b11  = ADDR_W'(ADDR_W'(t11) * ADDR_W'(r3_nc));
        n4_item.w00  = r3_w00;
        n4_item.w10  = r3_w10;
        n4_item.w01  = r3_w01;
        n4_item.w11  = r3_w11;
        n4_item.wval = r3_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_smp  <= (i_func == FUNC_SAMPLE);
            r1_bil  <= i_bilinear;
            r1_tu   <= TU_W'(i_u_coord) * TU_W'(w_eff) + (i_bilinear ? HALF : '0);
            r1_tv   <= TU_W'(i_v_coord) * TU_W'(h_eff) + (i_bilinear ? HALF : '0);
            r1_w    <= w_eff;
            r1_h    <= h_eff;
            r1_nc   <= nc_eff;
            r1_addr <= i_byte_addr;
            r1_val  <= i_byte_value;

            r2_smp  <= r1_smp;
            r2_bil  <= r1_bil;
            r2_cx0  <= clamp_c(x0, r1_w);
            r2_cx1  <= clamp_c(x1, r1_w);
            r2_cy0  <= clamp_c(y0, r1_h);
            r2_cy1  <= clamp_c(y1, r1_h);
            r2_fu   <= r1_bil ? r1_tu[UV_FRAC_BITS-1:0] : '0;
            r2_fv   <= r1_bil ? r1_tv[UV_FRAC_BITS-1:0] : '0;
            r2_w    <= r1_w;
            r2_nc   <= r1_nc;
            r2_addr <= r1_addr;
            r2_val  <= r1_val;

            r3_smp  <= r2_smp;
            r3_bil  <= r2_bil;
            r3_cx0  <= r2_cx0;
            r3_cx1  <= r2_cx1;
            r3_ro0  <= RO_W'(r2_cy0) * RO_W'(r2_w);
            r3_ro1  <= RO_W'(r2_cy1) * RO_W'(r2_w);
            r3_w00  <= WGT_W'(a_u) * WGT_W'(a_v);
            r3_w10  <= WGT_W'(r2_fu) * WGT_W'(a_v);
            r3_w01  <= WGT_W'(a_u) * WGT_W'(r2_fv);
            r3_w11  <= WGT_W'(r2_fu) * WGT_W'(r2_fv);
            r3_nc   <= r2_nc;
            r3_addr <= r2_addr;
            r3_val  <= r2_val;

            r4_item <= n4_item;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/txs_queue.sv =====
// Short queue of classified items between front and back.
`default_nettype none
module txs_queue
    import txs_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire t_txs_item i_item,
    input  wire logic      i_pop,
    output logic           o_full,
    output logic           o_empty,
    output t_txs_item      o_head
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_txs_item r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/txs_back.sv =====
// Back end: texel store, neighbor fetch, weighted accumulate and result register.
`default_nettype none
module txs_back
    import txs_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_empty,
    input  wire t_txs_item         i_q_item,
    output logic                   o_q_pop,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [COMP_W-1:0]      o_red,
    output logic [COMP_W-1:0]      o_green,
    output logic [COMP_W-1:0]      o_blue,
    output logic [COMP_W-1:0]      o_alpha
);
    localparam logic [ACC_W-1:0] RND = ACC_W'(1) << (ROUND_SH - 1);

    logic [7:0] r_mem [STORE_DEPTH];

    t_txs_state r_state, n_state;
    t_txs_item  r_cur;
    logic [2:0] r_step;
    logic       pop, start, issue, wr_en, load_out;
    logic [3:0] nsteps;
    logic       last_step, row;
    logic [1:0] k;
    logic [ADDR_W-1:0] addr_a, addr_b;
    logic [WGT_W-1:0]  wa, wb;

    logic [7:0]       r_rd_a, r_rd_b;
    logic             r_p1_v, r_p1_last;
    logic [1:0]       r_p1_k;
    logic [WGT_W-1:0] r_p1_wa, r_p1_wb;
    logic             r_p2_v, r_p2_last;
    logic [1:0]       r_p2_k;
    logic [ACC_W-1:0] r_pa, r_pb, r_acc, acc_sum, acc_rnd;
    logic [COMP_W-1:0] r_comp [4];
    logic              r_out_v;
    logic [COMP_W-1:0] r_red, r_green, r_blue, r_alpha;

    // step decode
    always_comb begin
        nsteps    = r_cur.bil ? {r_cur.nc, 1'b0} : {1'b0, r_cur.nc};
        last_step = ({1'b0, r_step} == nsteps - 4'd1);
        k         = r_cur.bil ? r_step[2:1] : r_step[1:0];
        row       = r_cur.bil & r_step[0];
        addr_a    = (row ? r_cur.b01 : r_cur.b00) + ADDR_W'(k);
        addr_b    = (row ? r_cur.b11 : r_cur.b10) + ADDR_W'(k);
        wa        = row ? r_cur.w01 : r_cur.w00;
        wb        = row ? r_cur.w11 : r_cur.w10;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (!i_q_empty && i_q_item.smp) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (last_step) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_p1_v && !r_p2_v) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_v || !i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        pop      = 1'b0;
        start    = 1'b0;
        wr_en    = 1'b0;
        issue    = 1'b0;
        load_out = 1'b0;
        case (r_state)
            S_IDLE: begin
                pop   = !i_q_empty;
                start = !i_q_empty && i_q_item.smp;
                wr_en = !i_q_empty && !i_q_item.smp;
            end
            S_RUN:   issue = 1'b1;
            S_DRAIN: issue = 1'b0;
            S_DONE:  load_out = !r_out_v || !i_stall;
            default: pop = 1'b0;
        endcase
    end

    assign o_q_pop = pop;

    always_comb begin
        acc_sum = r_acc + r_pa + r_pb;
        acc_rnd = acc_sum + RND;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_p1_v  <= 1'b0;
            r_p2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_p1_v  <= issue;
            r_p2_v  <= r_p1_v;
            if (load_out) begin
                r_out_v <= 1'b1;
            end else if (!i_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // texel store: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[i_q_item.b00] <= i_q_item.wval;
        end
        if (issue) begin
            r_rd_a <= r_mem[addr_a];
            r_rd_b <= r_mem[addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_cur  <= i_q_item;
            r_step <= '0;
            r_acc  <= '0;
            for (int i = 0; i < 4; i++) begin
                r_comp[i] <= '0;
            end
        end else begin
            if (issue) begin
                r_step <= r_step + 3'd1;
            end
            if (r_p2_v) begin
                if (r_p2_last) begin
                    r_comp[r_p2_k] <= acc_rnd[ROUND_SH+COMP_W-1:ROUND_SH];
                    r_acc          <= '0;
                end else begin
                    r_acc <= acc_sum;
                end
            end
        end
        r_p1_k    <= k;
        r_p1_last <= r_cur.bil ? row : 1'b1;
        r_p1_wa   <= wa;
        r_p1_wb   <= wb;
        r_p2_k    <= r_p1_k;
        r_p2_last <= r_p1_last;
        r_pa      <= ACC_W'(r_rd_a) * ACC_W'(r_p1_wa);
        r_pb      <= ACC_W'(r_rd_b) * ACC_W'(r_p1_wb);
        if (load_out) begin
            r_red   <= r_comp[0];
            r_green <= r_comp[1];
            r_blue  <= r_comp[2];
            r_alpha <= r_comp[3];
        end
    end

    assign o_valid = r_out_v;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;
    assign o_alpha = r_alpha;
endmodule
`default_nettype wire

// ===== hw/rtl/texture_sampler_point_bilinear_core.sv =====
// Top level of the point / bilinear texture sampler.
// A transaction on the input channel either writes one byte of the 256K-byte
// texel store (func 0) or samples it at normalized u,v in unsigned Q1.16
// (func 1). Point mode returns the texel at floor(u*width), floor(v*height);
// bilinear mode shifts by half a texel and blends the four neighbors, rounding
// once to Q8.8. Texel coordinates off the texture clamp to the edge texel, and
// components beyond the configured count read as zero. A four-stage front
// pipeline scales, clamps and forms addresses and weights; a short queue feeds
// the back end, which owns the texel store. The store has one write and two
// read ports, so the back end fetches two neighbors of one component per
// cycle. The front keeps accepting while the back end works, until the queue
// fills. Bytes of the store never written read back as arbitrary values. The
// configuration port takes tex_width (index 0), tex_height (1) and components
// (2); write them only while the block is idle. There is no clearing pass.
`default_nettype none
module texture_sampler_point_bilinear_core
    import txs_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic                 i_func,
    input  wire logic [ADDR_W-1:0]    i_byte_addr,
    input  wire logic [7:0]           i_byte_value,
    input  wire logic [UV_W-1:0]      i_u_coord,
    input  wire logic [UV_W-1:0]      i_v_coord,
    input  wire logic                 i_bilinear,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic [COMP_W-1:0]         o_red,
    output logic [COMP_W-1:0]         o_green,
    output logic [COMP_W-1:0]         o_blue,
    output logic [COMP_W-1:0]         o_alpha,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);
    logic [CFG_W-1:0] r_tex_width, r_tex_height;
    logic [NC_W-1:0]  r_components;
    logic             q_push, q_pop, q_full, q_empty;
    t_txs_item        q_in, q_head;

    // configuration registers; writes to unknown indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_width  <= CFG_W'(1);
            r_tex_height <= CFG_W'(1);
            r_components <= NC_W'(4);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TEX_WIDTH:  r_tex_width  <= i_cfg_data;
                CFG_TEX_HEIGHT: r_tex_height <= i_cfg_data;
                CFG_COMPONENTS: r_components <= i_cfg_data[NC_W-1:0];
                default:        r_components <= r_components;
            endcase
        end
    end

    // front: accept, scale, clamp, address
    txs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_func       (i_func),
        .i_byte_addr  (i_byte_addr),
        .i_byte_value (i_byte_value),
        .i_u_coord    (i_u_coord),
        .i_v_coord    (i_v_coord),
        .i_bilinear   (i_bilinear),
        .i_tex_width  (r_tex_width),
        .i_tex_height (r_tex_height),
        .i_components (r_components),
        .i_q_full     (q_full),
        .o_q_push     (q_push),
        .o_q_item     (q_in)
    );

    // hold classified transactions in order, writes and samples alike
    txs_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    // back: store access, blend, result register
    txs_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_item  (q_head),
        .o_q_pop   (q_pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_red     (o_red),
        .o_green   (o_green),
        .o_blue    (o_blue),
        .o_alpha   (o_alpha)
    );
endmodule
`default_nettype wire

// ===== hw/rtl/txs_checker.sv =====
// Port-level checks of the texture sampler, bound to the top level.
`default_nettype none
module txs_checker
    import txs_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_stall,
    input wire logic              o_valid,
    input wire logic              o_stall,
    input wire logic [COMP_W-1:0] o_red,
    input wire logic [COMP_W-1:0] o_green,
    input wire logic [COMP_W-1:0] o_blue,
    input wire logic [COMP_W-1:0] o_alpha
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_red) && $stable(o_alpha))
        else $error("result changed while stalled");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("not empty after reset");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_red <= 16'hFF00 && o_green <= 16'hFF00
                    && o_blue <= 16'hFF00 && o_alpha <= 16'hFF00)
        else $error("component above 255.0");
endmodule

bind texture_sampler_point_bilinear_core txs_checker u_chk (.*);
`default_nettype wire
